// ===== hdl/rfps_pkg.sv =====
// rfps_pkg: shared types, constants and the colour table for the panel scan block
// no dependencies; imported by every module under hdl

package rfps_pkg;

   // fixed field widths
   localparam int WIN_W     = 11;
   localparam int ROT_W     = 2;
   localparam int ADDR_IN_W = 20;
   localparam int BYTE_W    = 8;
   localparam int NIB_W     = 4;
   localparam int FULL_W    = 2 * WIN_W;   // unreduced buffer address
   localparam int PADDR_W   = 5;
   localparam int CSR_IDX_W = 3;
   localparam int PDATA_W   = 32;

   // opcodes of an input word
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EMIT  = 1'b1;

   // rotation codes
   localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_W = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_H = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION = 3'd4;

   // register reset values
   localparam logic [WIN_W-1:0] WINDOW_W_RESET = 11'd1200;
   localparam logic [WIN_W-1:0] WINDOW_H_RESET = 11'd1600;

   // colour for pixels outside the window
   localparam logic [NIB_W-1:0] COLOUR_WHITE = 4'h1;

   typedef struct packed {
      logic                 opcode;
      logic [ADDR_IN_W-1:0] address;
      logic [BYTE_W-1:0]    data;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] panel_byte;
      logic              to_second_half;
      logic              last_of_half;
      logic              last_of_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic [WIN_W-1:0] window_x;
      logic [WIN_W-1:0] window_y;
      logic [WIN_W-1:0] window_w;
      logic [WIN_W-1:0] window_h;
      logic [ROT_W-1:0] rotation;
   } cfg_type;

   typedef struct packed {
      logic in_window;
      logic odd;
   } pix_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_MUL,
      ST_REDUCE,
      ST_PICK,
      ST_FINISH
   } state_type;

   // fixed buffer-nibble to panel colour table
   function automatic logic [NIB_W-1:0] colour_of(input logic [NIB_W-1:0] nib);
      logic [NIB_W-1:0] c;
      case (nib)
         4'h0:    c = 4'h0;
         4'h1:    c = 4'h5;
         4'h2:    c = 4'h6;
         4'h3:    c = 4'h3;
         4'h4:    c = 4'h3;
         4'h5:    c = 4'h2;
         default: c = 4'h1;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/rfps_csr.sv =====
// rfps_csr: window and rotation registers behind the APB-style port
// depends on rfps_pkg

module rfps_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rfps_pkg::PADDR_W-1:0] paddr,
   input  logic [rfps_pkg::PDATA_W-1:0] pwdata,
   output logic [rfps_pkg::PDATA_W-1:0] prdata,
   output logic                         pready,
   output rfps_pkg::cfg_type            cfg
);
   import rfps_pkg::*;

   logic [CSR_IDX_W-1:0] idx;
   logic                 wr;
   cfg_type              cfg_ff;
   cfg_type              cfg_in;

   assign idx    = paddr[PADDR_W-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_WINDOW_X: cfg_in.window_x = pwdata[WIN_W-1:0];
            REG_WINDOW_Y: cfg_in.window_y = pwdata[WIN_W-1:0];
            REG_WINDOW_W: cfg_in.window_w = pwdata[WIN_W-1:0];
            REG_WINDOW_H: cfg_in.window_h = pwdata[WIN_W-1:0];
            REG_ROTATION: cfg_in.rotation = pwdata[ROT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_x <= '0;
         cfg_ff.window_y <= '0;
         cfg_ff.window_w <= WINDOW_W_RESET;
         cfg_ff.window_h <= WINDOW_H_RESET;
         cfg_ff.rotation <= ROT_0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_WINDOW_X: prdata = PDATA_W'(cfg_ff.window_x);
         REG_WINDOW_Y: prdata = PDATA_W'(cfg_ff.window_y);
         REG_WINDOW_W: prdata = PDATA_W'(cfg_ff.window_w);
         REG_WINDOW_H: prdata = PDATA_W'(cfg_ff.window_h);
         REG_ROTATION: prdata = PDATA_W'(cfg_ff.rotation);
         default:      prdata = '0;
      endcase
   end

endmodule

// ===== hdl/rfps_frame_mem.sv =====
// rfps_frame_mem: single-port byte frame memory with registered read data
// depends on rfps_pkg

module rfps_frame_mem #(
   parameter int DEPTH  = 1048576,
   parameter int ADDR_W = 20
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic                        re,
   input  logic [ADDR_W-1:0]           addr,
   input  logic [rfps_pkg::BYTE_W-1:0] wdata,
   output logic [rfps_pkg::BYTE_W-1:0] rdata
);
   import rfps_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   assign rdata = rdata_ff;

   // one access per cycle, write wins
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else if (re) begin
         rdata_ff <= mem[addr];
      end
   end

endmodule

// ===== hdl/rfps_addr_reduce.sv =====
// rfps_addr_reduce: shared compare-subtract unit that folds an address into the buffer
// depends on rfps_pkg; one restoring step per cycle while step is asserted

module rfps_addr_reduce #(
   parameter int BUFFER_BYTES = 1048576
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [rfps_pkg::FULL_W-1:0]        load_value,
   input  logic                               step,
   output logic                               done,
   output logic [$clog2(BUFFER_BYTES)-1:0]    rem
);
   import rfps_pkg::*;

   localparam int ADDR_W    = $clog2(BUFFER_BYTES);
   localparam int LOG_FLOOR = $clog2(BUFFER_BYTES + 1) - 1;
   localparam int MOD_STEPS = (FULL_W > LOG_FLOOR) ? FULL_W - LOG_FLOOR : 0;
   localparam int STEP_W    = (MOD_STEPS > 0) ? $clog2(MOD_STEPS + 1) : 1;
   localparam logic [FULL_W-1:0] MOD_TOP =
      FULL_W'(longint'(BUFFER_BYTES) << ((MOD_STEPS > 0) ? MOD_STEPS - 1 : 0));

   logic [FULL_W-1:0] r_ff;
   logic [FULL_W-1:0] r_in;
   logic [FULL_W-1:0] d_ff;
   logic [FULL_W-1:0] d_in;
   logic [STEP_W-1:0] cnt_ff;
   logic [STEP_W-1:0] cnt_in;

   assign done = (cnt_ff == '0);
   assign rem  = r_ff[ADDR_W-1:0];

   // subtract the shifted buffer size where it fits, then halve it
   always_comb begin
      r_in   = r_ff;
      d_in   = d_ff;
      cnt_in = cnt_ff;
      if (load) begin
         r_in   = load_value;
         d_in   = MOD_TOP;
         cnt_in = STEP_W'(MOD_STEPS);
      end else if (step && !done) begin
         if (r_ff >= d_ff) begin
            r_in = r_ff - d_ff;
         end
         d_in   = d_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      d_ff <= d_in;
   end

endmodule

// ===== hdl/rfps_pixel_unit.sv =====
// rfps_pixel_unit: shared rotation, window test and buffer address unit, one pixel per pass
// depends on rfps_pkg

module rfps_pixel_unit #(
   parameter int PANEL_WIDTH  = 1200,
   parameter int PANEL_HEIGHT = 1600,
   parameter int COORD_W      = 12
) (
   input  logic                         clock,
   input  logic                         map_en,
   input  logic [COORD_W-1:0]           px,
   input  logic [COORD_W-1:0]           py,
   input  rfps_pkg::cfg_type            cfg,
   output rfps_pkg::pix_status_type     status,
   output logic [rfps_pkg::FULL_W-1:0]  addr
);
   import rfps_pkg::*;

   localparam logic [COORD_W-1:0] X_LAST = COORD_W'(PANEL_WIDTH - 1);
   localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(PANEL_HEIGHT - 1);

   logic [COORD_W-1:0] lx;
   logic [COORD_W-1:0] ly;
   logic [COORD_W-1:0] x_lo;
   logic [COORD_W-1:0] x_hi;
   logic [COORD_W-1:0] y_lo;
   logic [COORD_W-1:0] y_hi;
   logic               in_win;
   logic [WIN_W-1:0]   bx;
   logic [WIN_W-1:0]   by;
   logic [WIN_W-1:0]   bx_ff;
   logic [WIN_W-1:0]   by_ff;
   logic               inside_ff;
   logic [WIN_W:0]     w_plus;
   logic [WIN_W-1:0]   stride;
   logic [FULL_W-1:0]  by_ext;
   logic [FULL_W-1:0]  stride_ext;
   logic [FULL_W-1:0]  prod;

   // panel to logical coordinates
   always_comb begin
      case (cfg.rotation)
         ROT_90: begin
            lx = py;
            ly = X_LAST - px;
         end
         ROT_180: begin
            lx = X_LAST - px;
            ly = Y_LAST - py;
         end
         ROT_270: begin
            lx = Y_LAST - py;
            ly = px;
         end
         default: begin
            lx = px;
            ly = py;
         end
      endcase
   end

   // window test and offsets
   assign x_lo   = COORD_W'(cfg.window_x);
   assign y_lo   = COORD_W'(cfg.window_y);
   assign x_hi   = COORD_W'(cfg.window_x) + COORD_W'(cfg.window_w);
   assign y_hi   = COORD_W'(cfg.window_y) + COORD_W'(cfg.window_h);
   assign in_win = (lx >= x_lo) && (lx < x_hi) && (ly >= y_lo) && (ly < y_hi);
   assign bx     = WIN_W'(lx - x_lo);
   assign by     = WIN_W'(ly - y_lo);

   always_ff @(posedge clock) begin
      if (map_en) begin
         bx_ff     <= bx;
         by_ff     <= by;
         inside_ff <= in_win;
      end
   end

   assign status.in_window = inside_ff;
   assign status.odd       = bx_ff[0];

   // row stride is half the window width, rounded up
   assign w_plus     = {1'b0, cfg.window_w} + 1'b1;
   assign stride     = w_plus[WIN_W:1];
   assign by_ext     = FULL_W'(by_ff);
   assign stride_ext = FULL_W'(stride);
   assign prod       = by_ext * stride_ext;
   assign addr       = prod + FULL_W'(bx_ff >> 1);

endmodule

// ===== hdl/rotated_framebuffer_panel_scan.sv =====
// Rotated 4-bit frame buffer scanned out as panel bytes, left half-panel then right.
// A write word stores one byte in a single-port frame memory; an emit word produces one
// panel byte of two pixels. A sequencer runs each pixel through one shared rotation and
// window unit and, for a pixel inside the window, through a shared compare-subtract unit
// that folds the address into the buffer, S steps with S = 22 - floor(log2 BUFFER_BYTES)
// (0 from 4 Mi bytes up, 2 at the default size). The two pixels of an emit are handled
// one after the other, since they share the one memory port and the one reduction unit,
// and a new input word is taken only once the previous word is through. The memory needs
// no clearing pass; only written bytes are ever meant to be read. The result register
// frees the input side as soon as a byte is loaded; the next byte waits only if the
// previous one has not been taken.
// depends on rfps_pkg, rfps_csr, rfps_frame_mem, rfps_addr_reduce, rfps_pixel_unit

module rotated_framebuffer_panel_scan #(
   parameter int PANEL_WIDTH  = 1200,
   parameter int PANEL_HEIGHT = 1600,
   parameter int BUFFER_BYTES = 1048576
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  rfps_pkg::req_payload_type    req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rfps_pkg::rsp_payload_type    rsp_payload,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rfps_pkg::PADDR_W-1:0] paddr,
   input  logic [rfps_pkg::PDATA_W-1:0] pwdata,
   output logic [rfps_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);
   import rfps_pkg::*;

   localparam int HALF_PIXELS   = PANEL_WIDTH / 2;
   localparam int BYTES_PER_ROW = PANEL_WIDTH / 4;
   localparam int PX_W          = $clog2(PANEL_WIDTH);
   localparam int PY_W          = $clog2(PANEL_HEIGHT);
   localparam int PXY_W         = (PX_W > PY_W) ? PX_W : PY_W;
   localparam int COORD_W       = (PXY_W > WIN_W + 1) ? PXY_W : WIN_W + 1;
   localparam int ROW_W         = $clog2(PANEL_HEIGHT);
   localparam int COL_W         = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
   localparam int MEM_AW        = $clog2(BUFFER_BYTES);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(BYTES_PER_ROW - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(PANEL_HEIGHT - 1);

   state_type         state_ff;
   state_type         state_in;
   logic              op_ff;
   logic              op_in;
   logic [BYTE_W-1:0] wdata_ff;
   logic [BYTE_W-1:0] wdata_in;
   logic              pix_sel_ff;
   logic              pix_sel_in;
   logic [NIB_W-1:0]  left_ff;
   logic [NIB_W-1:0]  left_in;
   logic [NIB_W-1:0]  right_ff;
   logic [NIB_W-1:0]  right_in;
   logic              scan_half_ff;
   logic              scan_half_in;
   logic [ROW_W-1:0]  scan_row_ff;
   logic [ROW_W-1:0]  scan_row_in;
   logic [COL_W-1:0]  scan_col_ff;
   logic [COL_W-1:0]  scan_col_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_payload_type   rsp_data_ff;
   rsp_payload_type   rsp_data_in;

   cfg_type           cfg;
   pix_status_type    pix_status;
   logic [FULL_W-1:0] pix_addr;
   logic [COORD_W-1:0] px;
   logic [COORD_W-1:0] py;
   logic              map_en;
   logic              red_load;
   logic              red_step;
   logic              red_done;
   logic [FULL_W-1:0] red_value;
   logic [MEM_AW-1:0] red_rem;
   logic              mem_we;
   logic              mem_re;
   logic [BYTE_W-1:0] mem_rdata;
   logic [NIB_W-1:0]  nib;
   logic [NIB_W-1:0]  colour;
   logic              last_half;

   rfps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rfps_pixel_unit #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT),
      .COORD_W      (COORD_W)
   ) u_pixel (
      .clock  (clock),
      .map_en (map_en),
      .px     (px),
      .py     (py),
      .cfg    (cfg),
      .status (pix_status),
      .addr   (pix_addr)
   );

   rfps_addr_reduce #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_reduce (
      .clock      (clock),
      .reset      (reset),
      .load       (red_load),
      .load_value (red_value),
      .step       (red_step),
      .done       (red_done),
      .rem        (red_rem)
   );

   rfps_frame_mem #(
      .DEPTH  (BUFFER_BYTES),
      .ADDR_W (MEM_AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (red_rem),
      .wdata (wdata_ff),
      .rdata (mem_rdata)
   );

   // panel pixel under the scan
   assign px = (scan_half_ff ? COORD_W'(HALF_PIXELS) : '0) + COORD_W'({scan_col_ff, 1'b0})
             + COORD_W'(pix_sel_ff);
   assign py = COORD_W'(scan_row_ff);

   // nibble pick and colour lookup
   assign nib       = pix_status.odd ? mem_rdata[NIB_W-1:0] : mem_rdata[BYTE_W-1:NIB_W];
   assign colour    = pix_status.in_window ? colour_of(nib) : COLOUR_WHITE;
   assign last_half = (scan_col_ff == COL_LAST) && (scan_row_ff == ROW_LAST);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // sequencer: next state and controls
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      wdata_in     = wdata_ff;
      pix_sel_in   = pix_sel_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      scan_half_in = scan_half_ff;
      scan_row_in  = scan_row_ff;
      scan_col_in  = scan_col_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      map_en       = 1'b0;
      red_load     = 1'b0;
      red_step     = 1'b0;
      red_value    = pix_addr;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_payload.opcode;
               if (req_payload.opcode == OP_WRITE) begin
                  red_load  = 1'b1;
                  red_value = FULL_W'(req_payload.address);
                  wdata_in  = req_payload.data;
                  state_in  = ST_REDUCE;
               end else begin
                  pix_sel_in = 1'b0;
                  state_in   = ST_MAP;
               end
            end
         end
         ST_MAP: begin
            map_en   = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (pix_status.in_window) begin
               red_load = 1'b1;
               state_in = ST_REDUCE;
            end else begin
               state_in = ST_PICK;
            end
         end
         ST_REDUCE: begin
            red_step = 1'b1;
            if (red_done) begin
               if (op_ff == OP_WRITE) begin
                  mem_we   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  mem_re   = 1'b1;
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            if (!pix_sel_ff) begin
               left_in    = colour;
               pix_sel_in = 1'b1;
               state_in   = ST_MAP;
            end else begin
               right_in = colour;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.panel_byte     = {left_ff, right_ff};
               rsp_data_in.to_second_half = scan_half_ff;
               rsp_data_in.last_of_half   = last_half;
               rsp_data_in.last_of_frame  = last_half && scan_half_ff;
               // advance the scan
               if (scan_col_ff == COL_LAST) begin
                  scan_col_in = '0;
                  if (scan_row_ff == ROW_LAST) begin
                     scan_row_in  = '0;
                     scan_half_in = !scan_half_ff;
                  end else begin
                     scan_row_in = scan_row_ff + 1'b1;
                  end
               end else begin
                  scan_col_in = scan_col_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_WRITE;
         pix_sel_ff   <= 1'b0;
         scan_half_ff <= 1'b0;
         scan_row_ff  <= '0;
         scan_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         pix_sel_ff   <= pix_sel_in;
         scan_half_ff <= scan_half_in;
         scan_row_ff  <= scan_row_in;
         scan_col_ff  <= scan_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wdata_ff    <= wdata_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   // a result word only appears out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result word raised outside finish step");

   // end of frame is only ever flagged on the last word of the right half
   a_frame_end_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last_of_frame) |->
         (rsp_data_ff.last_of_half && rsp_data_ff.to_second_half))
      else $error("frame end without half end on right controller");

   // scan position stays on the panel
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (scan_col_ff <= COL_LAST) && (scan_row_ff <= ROW_LAST))
      else $error("scan position beyond panel");

   // a pixel in the window is only picked after its memory read
   a_pick_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK && pix_status.in_window) |-> $past(mem_re))
      else $error("pixel picked without a memory read");

   // an accepted write goes straight to the address fold
   a_write_path: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.opcode == OP_WRITE) |=> state_ff == ST_REDUCE)
      else $error("write word did not enter address fold");
`endif

endmodule
